// ===== design/xmbt_pkg.sv =====
package xmbt_pkg;

   localparam int KEY_BITS = 16;
   localparam int VAL_W = 16;
   localparam int MEX_W = 17;
   // widest per-level pair store address, also the clear sweep counter width
   localparam int AW = (KEY_BITS > 1) ? KEY_BITS - 1 : 1;
   localparam int LVL_W = $clog2(KEY_BITS + 1);
   localparam logic [MEX_W-1:0] MEX_ALL_FULL = MEX_W'(1) << KEY_BITS;

   // address width of the pair store in level j (pairs indexed by parent node)
   function automatic int caw(input int j);
      return (j > 1) ? j - 1 : 1;
   endfunction

   typedef struct packed {
      logic                act;
      logic [KEY_BITS-1:0] path;
   } down_type;

   typedef struct packed {
      logic act;
      logic full;
   } up_type;

   typedef struct packed {
      logic                re;
      logic                we;
      logic [KEY_BITS-1:0] addr;
      logic [1:0]          wdata;
   } ram_req_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UP,
      ST_DOWN
   } state_type;

endpackage

// ===== design/xmbt_ram.sv =====
module xmbt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     re,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/xmbt_cell.sv =====
module xmbt_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [xmbt_pkg::LVL_W-1:0]    level,
   input  logic [xmbt_pkg::KEY_BITS-1:0] key,
   input  logic [xmbt_pkg::KEY_BITS-1:0] acc,
   input  logic                          ins_rd,
   input  xmbt_pkg::down_type            down_in,
   input  xmbt_pkg::up_type              up_in,
   input  logic [1:0]                    rdata,
   output xmbt_pkg::ram_req_type         ram_req,
   output xmbt_pkg::down_type            down_out,
   output xmbt_pkg::up_type              up_out
);

   logic                          pend_ff;
   logic [xmbt_pkg::KEY_BITS-1:0] path_ff;
   xmbt_pkg::down_type            down_ff;
   xmbt_pkg::down_type            down_in_w;
   xmbt_pkg::up_type              up_ff;
   xmbt_pkg::up_type              up_in_w;
   logic [1:0]                    pair;

   // request to the pair store and the new pair on the way up
   always_comb begin
      int p;
      p = xmbt_pkg::KEY_BITS - int'(level);
      ram_req = '0;
      pair = rdata;
      pair[key[p]] = up_in.full;
      if (ins_rd) begin
         ram_req.re = 1'b1;
         ram_req.addr = key >> (p + 1);
      end
      if (down_in.act) begin
         ram_req.re = 1'b1;
         ram_req.addr = down_in.path >> (p + 1);
      end
      if (up_in.act) begin
         ram_req.we = 1'b1;
         ram_req.addr = key >> (p + 1);
         ram_req.wdata = pair;
      end
   end

   // pick the child that keeps the result bit at zero if it is not full
   always_comb begin
      int p;
      logic b;
      p = xmbt_pkg::KEY_BITS - int'(level);
      b = acc[p];
      down_in_w.act = pend_ff;
      down_in_w.path = path_ff;
      down_in_w.path[p] = b ^ rdata[b];
      up_in_w.act = up_in.act;
      up_in_w.full = &pair;
   end

   always_ff @(posedge clock) begin
      path_ff <= down_in.path;
      down_ff.path <= down_in_w.path;
      up_ff.full <= up_in_w.full;
      if (reset) begin
         pend_ff <= 1'b0;
         down_ff.act <= 1'b0;
         up_ff.act <= 1'b0;
      end else begin
         pend_ff <= down_in.act;
         down_ff.act <= down_in_w.act;
         up_ff.act <= up_in_w.act;
      end
   end

   assign down_out = down_ff;
   assign up_out = up_ff;

endmodule

// ===== design/xor_mex_bit_trie.sv =====
// insert: one parallel read of every level, then one level a cycle upward
// query: rsp beat after the seed register and then a read and a decide register per level,
//   or in the cycle after acceptance when the whole key space is present
// one item at a time: busy stays high until the item's last level is done
// the receiver cannot stall: rsp_valid is a one-cycle strobe
// reset (synchronous): clears accumulator, then sweeps every pair store address clearing the trie
module xor_mex_bit_trie (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [xmbt_pkg::VAL_W-1:0]    req_value,
   output logic                          rsp_valid,
   output logic [xmbt_pkg::MEX_W-1:0]    rsp_mex
);

   localparam int K = xmbt_pkg::KEY_BITS;

   xmbt_pkg::state_type   state_ff, state_in;
   logic [xmbt_pkg::AW-1:0] clr_cnt_ff;
   logic [K-1:0]          acc_ff;
   logic [K-1:0]          key_ff;
   logic                  root_ff;
   logic                  upseed_ff;
   logic                  dnseed_ff;
   logic                  rsp_valid_ff;
   logic [xmbt_pkg::MEX_W-1:0] rsp_mex_ff;

   logic                  accept;
   logic                  clearing;
   logic                  ins_rd;
   logic [K-1:0]          req_key;

   // cell chains: down runs level 1 to K, up runs level K to 1
   xmbt_pkg::down_type    down_w [K+1];
   xmbt_pkg::up_type      up_w   [K+2];
   xmbt_pkg::ram_req_type req_w  [K+1];
   logic [1:0]            rd_w   [K+1];

   assign accept = start && !busy;
   assign req_key = req_value[K-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         xmbt_pkg::ST_CLEAR: begin
            if (&clr_cnt_ff) state_in = xmbt_pkg::ST_IDLE;
         end
         xmbt_pkg::ST_IDLE: begin
            if (accept) begin
               if (!req_mode) state_in = xmbt_pkg::ST_READ;
               else if (!root_ff) state_in = xmbt_pkg::ST_DOWN;
            end
         end
         xmbt_pkg::ST_READ: state_in = xmbt_pkg::ST_UP;
         xmbt_pkg::ST_UP: begin
            if (up_w[1].act) state_in = xmbt_pkg::ST_IDLE;
         end
         xmbt_pkg::ST_DOWN: begin
            if (down_w[K].act) state_in = xmbt_pkg::ST_IDLE;
         end
         default: state_in = xmbt_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      busy = 1'b1;
      clearing = 1'b0;
      ins_rd = 1'b0;
      case (state_ff)
         xmbt_pkg::ST_CLEAR: clearing = 1'b1;
         xmbt_pkg::ST_IDLE:  busy = 1'b0;
         xmbt_pkg::ST_READ:  ins_rd = 1'b1;
         default:            busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && !req_mode) key_ff <= req_key;
      if (down_w[K].act) begin
         rsp_mex_ff <= xmbt_pkg::MEX_W'(down_w[K].path ^ acc_ff);
      end else if (accept && req_mode) begin
         rsp_mex_ff <= xmbt_pkg::MEX_ALL_FULL;
      end
      if (reset) begin
         state_ff <= xmbt_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
         acc_ff <= '0;
         root_ff <= 1'b0;
         upseed_ff <= 1'b0;
         dnseed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (accept && req_mode) acc_ff <= acc_ff ^ req_key;
         if (up_w[1].act) root_ff <= up_w[1].full;
         upseed_ff <= ins_rd;
         dnseed_ff <= accept && req_mode && !root_ff;
         // full-root queries answer at once, otherwise the last cell answers
         rsp_valid_ff <= down_w[K].act || (accept && req_mode && root_ff);
      end
   end

   // seeds entering the chains
   assign down_w[0].act = dnseed_ff;
   assign down_w[0].path = '0;
   assign up_w[K+1].act = upseed_ff;
   assign up_w[K+1].full = 1'b1;   // leaf of the inserted key becomes present
   assign req_w[0] = '0;
   assign rd_w[0] = '0;
   assign up_w[0] = '0;

   for (genvar j = 1; j <= K; j++) begin : g_level
      localparam int CW = xmbt_pkg::caw(j);
      logic [CW-1:0] addr;

      xmbt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .level    (xmbt_pkg::LVL_W'(j)),
         .key      (key_ff),
         .acc      (acc_ff),
         .ins_rd   (ins_rd),
         .down_in  (down_w[j-1]),
         .up_in    (up_w[j+1]),
         .rdata    (rd_w[j]),
         .ram_req  (req_w[j]),
         .down_out (down_w[j]),
         .up_out   (up_w[j])
      );

      // clear sweep overrides the cell's port during reset recovery
      assign addr = clearing ? clr_cnt_ff[CW-1:0] : req_w[j].addr[CW-1:0];

      xmbt_ram #(
         .WIDTH (2),
         .DEPTH (2 ** CW)
      ) u_ram (
         .clock (clock),
         .re    (req_w[j].re),
         .we    (clearing || req_w[j].we),
         .addr  (addr),
         .wdata (clearing ? 2'b00 : req_w[j].wdata),
         .rdata (rd_w[j])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mex = rsp_mex_ff;

   // last upward step always ends the insert
   a_up_done: assert property (@(posedge clock) disable iff (reset)
      up_w[1].act |=> state_ff == xmbt_pkg::ST_IDLE)
      else $error("insert did not finish after root update");

   // the set only grows, so the root stays full
   a_root_keep: assert property (@(posedge clock) disable iff (reset)
      root_ff |=> root_ff)
      else $error("root full flag dropped");

   // the last cell finishing a walk yields a response
   a_walk_rsp: assert property (@(posedge clock) disable iff (reset)
      down_w[K].act |=> rsp_valid_ff)
      else $error("walk finished without response");

   // no walk runs while the block reports idle
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == xmbt_pkg::ST_IDLE |-> !down_w[K].act && !up_w[1].act)
      else $error("chain active while idle");

endmodule

// ===== sim/tb_xor_mex_bit_trie.sv =====
module tb_xor_mex_bit_trie;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;
   localparam int   KEY_SPAN    = 1 << xmbt_pkg::KEY_BITS;

   // scoreboard: shadow trie as a plain presence array plus the accumulator
   class mex_scoreboard;
      bit            present [KEY_SPAN];
      int            key_count;
      logic [xmbt_pkg::KEY_BITS-1:0] acc;
      logic [xmbt_pkg::MEX_W-1:0]    mex_due [$];
      int            errors;

      function new();
         key_count = 0;
         acc = '0;
         errors = 0;
      endfunction

      task report_mismatch(string what, logic [xmbt_pkg::MEX_W-1:0] want,
                           logic [xmbt_pkg::MEX_W-1:0] got);
         $display("mismatch at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
         errors++;
      endtask

      // smallest v with (v ^ acc) absent; whole space present gives 2^KEY_BITS
      function logic [xmbt_pkg::MEX_W-1:0] smallest_absent();
         int v;
         if (key_count == KEY_SPAN) return xmbt_pkg::MEX_ALL_FULL;
         for (v = 0; v < KEY_SPAN; v++)
            if (!present[v ^ acc]) return xmbt_pkg::MEX_W'(v);
         return xmbt_pkg::MEX_ALL_FULL;
      endfunction

      function void note_beat(logic mode, logic [xmbt_pkg::VAL_W-1:0] value);
         logic [xmbt_pkg::KEY_BITS-1:0] k;
         k = value[xmbt_pkg::KEY_BITS-1:0];
         if (mode == MODE_INSERT) begin
            if (!present[k]) begin
               present[k] = 1;
               key_count++;
            end
         end else begin
            acc ^= k;
            mex_due.push_back(smallest_absent());
         end
      endfunction

      task check_beat(logic [xmbt_pkg::MEX_W-1:0] mex);
         logic [xmbt_pkg::MEX_W-1:0] want;
         if (mex_due.size() == 0) begin
            report_mismatch("rsp beat with nothing pending", '0, mex);
            return;
         end
         want = mex_due.pop_front();
         if (mex !== want) report_mismatch("mex differs", want, mex);
      endtask
   endclass

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       start = 0;
   logic                       busy;
   logic                       req_mode = 0;
   logic [xmbt_pkg::VAL_W-1:0] req_value = '0;
   logic                       rsp_valid;
   logic [xmbt_pkg::MEX_W-1:0] rsp_mex;

   mex_scoreboard sb;
   int            send_idle_pct;

   xor_mex_bit_trie dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_mex(rsp_mex)
   );

   always #1 clock = ~clock;

   // result side: check every rsp beat at a clock edge where rsp_valid is high
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_beat(rsp_mex);
   end

   // drive one beat, random idle gap first; hold start until accepted
   // start stays high after acceptance so a following beat can go back to back
   task automatic send_beat(logic mode, logic [xmbt_pkg::VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      // this edge accepted the beat
      sb.note_beat(mode, value);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.mex_due.size() != 0) @(posedge clock);
      // a trailing insert may still be updating flags
      repeat (2 * xmbt_pkg::KEY_BITS + 8) @(posedge clock);
   endtask

   // random value biased to small neighborhoods near zero and near all ones so mex walks go deep
   function automatic logic [xmbt_pkg::VAL_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return xmbt_pkg::VAL_W'($urandom_range(63));
         1: return xmbt_pkg::VAL_W'($urandom_range(15)) ^ 16'hFFF0;
         default: return xmbt_pkg::VAL_W'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count, int idle_pct);
      int i;
      send_idle_pct = idle_pct;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 55) send_beat(MODE_INSERT, pick_value());
         else send_beat(MODE_QUERY,
                        ($urandom_range(1)) ? xmbt_pkg::VAL_W'(0) : pick_value());
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // reset sweep holds busy high; send_beat waits on it

      // directed: empty set, extremes, duplicate insert, accumulator toggles
      send_beat(MODE_QUERY, 16'h0000);
      send_beat(MODE_QUERY, 16'hFFFF);
      send_beat(MODE_INSERT, 16'h0000);
      send_beat(MODE_INSERT, 16'hFFFF);
      send_beat(MODE_QUERY, 16'h0000);
      send_beat(MODE_QUERY, 16'hFFFF);
      send_beat(MODE_INSERT, 16'h0000);
      send_beat(MODE_INSERT, 16'h0001);
      send_beat(MODE_INSERT, 16'h0002);
      send_beat(MODE_INSERT, 16'hFFFE);
      send_beat(MODE_QUERY, 16'hAAAA);
      send_beat(MODE_QUERY, 16'h5555);
      send_beat(MODE_QUERY, 16'hFFFF);
      send_beat(MODE_QUERY, 16'h8000);
      // pause until every result has landed
      wait_drained();

      random_phase(220, 32);
      random_phase(220, 55);
      random_phase(200, 0);
      wait_drained();

      if (sb.errors == 0 && sb.mex_due.size() == 0) begin
         $display("tb_xor_mex_bit_trie OK");
      end else begin
         $display("tb_xor_mex_bit_trie NOT OK");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("tb_xor_mex_bit_trie NOT OK");
      $finish;
   end

endmodule
